>>> hw/rtl/lprd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_pkg
// Shared types and constants of the length-prefixed record deframer.
// ----------------------------------------------------------------------------
package lprd_pkg;

   localparam int BYTE_COUNT_WIDTH_DEFAULT = 48;
   localparam int QUEUE_DEPTH_DEFAULT      = 4;

   localparam int LENGTH_W      = 32;
   localparam int RECORD_W      = 32;
   localparam int BYTE_TOTAL_W  = 48;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_HEADER_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RAW_LENGTH    = 1'd1;

   localparam logic [LENGTH_W-1:0] MAX_HEADER_RESET = LENGTH_W'(16 * 1024 * 1024);
   localparam logic [LENGTH_W-1:0] MAX_RAW_RESET    = LENGTH_W'(512 * 1024 * 1024);

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_RECORD = 2'd1,
      KIND_FINISH = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK               = 3'd0,
      ST_HEADER_TOO_LARGE = 3'd1,
      ST_NONZERO_PADDING  = 3'd2,
      ST_SHORT_HEADER     = 3'd3,
      ST_SHORT_RAW_LENGTH = 3'd4,
      ST_RAW_TOO_LARGE    = 3'd5,
      ST_SHORT_RAW        = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      PH_HLEN = 3'd0,
      PH_HDR  = 3'd1,
      PH_RLEN = 3'd2,
      PH_RAW  = 3'd3,
      PH_PAD  = 3'd4,
      PH_ERR  = 3'd5
   } phase_type;

   typedef struct packed {
      kind_type                 out_kind;
      logic [7:0]               header_byte;
      logic                     header_last;
      logic [LENGTH_W-1:0]      raw_length;
      status_type               status;
      logic [RECORD_W-1:0]      record_total;
      logic [BYTE_TOTAL_W-1:0]  byte_total;
   } rsp_item_type;

endpackage

>>> hw/rtl/length_prefixed_record_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_record_deframer
// Parses a byte stream of length-prefixed records and reports header bytes,
// record completions and an end-of-stream summary.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : push an item (stream byte, or end of stream with req_op high)
//            when req_full is low. One item per cycle is taken while req_full is low.
//   rsp_*  : a result item waits on the ports while rsp_empty is low and
//            leaves with rsp_pop. Raw payload bytes and prefix bytes give
//            no result item; header bytes, accepted raw lengths and end of
//            stream give one each.
//   csr_*  : limit writes, taken in the cycle csr_wr_en is high; write them
//            only while the block is idle.
// A result enters the queue the cycle after its item is accepted and shows
// on the ports once it is the head item. One item per cycle is taken while
// req_full is low; the combinational parse step feeds a QUEUE_DEPTH entry queue.
// When the receiver stalls, results collect in the queue; req_full rises
// once it holds QUEUE_DEPTH items and stays up until a pop.
// On reset the queue empties, parser state clears and both limits return
// to 16 MiB and 512 MiB.
// ----------------------------------------------------------------------------
module length_prefixed_record_deframer #(
   parameter int BYTE_COUNT_WIDTH = lprd_pkg::BYTE_COUNT_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH      = lprd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [lprd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lprd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_op,
   input  logic [7:0]                            req_data_byte,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [1:0]                            rsp_out_kind,
   output logic [7:0]                            rsp_header_byte,
   output logic                                  rsp_header_last,
   output logic [lprd_pkg::LENGTH_W-1:0]         rsp_raw_length,
   output logic [2:0]                            rsp_status,
   output logic [lprd_pkg::RECORD_W-1:0]         rsp_record_total,
   output logic [lprd_pkg::BYTE_TOTAL_W-1:0]     rsp_byte_total
);

   logic                   q_full;
   logic                   accept;
   logic                   res_valid;
   lprd_pkg::rsp_item_type res_item;
   lprd_pkg::rsp_item_type head_item;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   lprd_parse #(
      .BYTE_COUNT_WIDTH (BYTE_COUNT_WIDTH)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_valid     (accept),
      .in_op        (req_op),
      .in_data_byte (req_data_byte),
      .out_valid    (res_valid),
      .out_item     (res_item)
   );

   lprd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_item (res_item),
      .full      (q_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head_item (head_item)
   );

   assign rsp_out_kind     = head_item.out_kind;
   assign rsp_header_byte  = head_item.header_byte;
   assign rsp_header_last  = head_item.header_last;
   assign rsp_raw_length   = head_item.raw_length;
   assign rsp_status       = head_item.status;
   assign rsp_record_total = head_item.record_total;
   assign rsp_byte_total   = head_item.byte_total;

endmodule

>>> hw/rtl/lprd_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_parse
// Front end: takes one stream item per cycle, walks the record grammar and
// emits at most one result item per input item.
// ----------------------------------------------------------------------------
module lprd_parse #(
   parameter int BYTE_COUNT_WIDTH = lprd_pkg::BYTE_COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [lprd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lprd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                in_valid,
   input  logic                                in_op,
   input  logic [7:0]                          in_data_byte,
   output logic                                out_valid,
   output lprd_pkg::rsp_item_type              out_item
);

   localparam int LW = lprd_pkg::LENGTH_W;
   localparam int RW = lprd_pkg::RECORD_W;

   logic [LW-1:0]               max_hdr_ff;
   logic [LW-1:0]               max_raw_ff;

   lprd_pkg::phase_type         phase_ff, phase_in;
   logic [1:0]                  idx_ff, idx_in;
   logic [23:0]                 acc_ff, acc_in;
   logic [LW-1:0]               rem_ff, rem_in;
   lprd_pkg::status_type        err_ff, err_in;
   logic [RW-1:0]               rec_ff, rec_in;
   logic [BYTE_COUNT_WIDTH-1:0] byte_cnt_ff, byte_cnt_in;

   logic [LW-1:0]               prefix_len;
   logic                        prefix_done;
   logic                        rem_last;
   logic [23:0]                 acc_ins;
   logic [2:0]                  add_amt;
   logic                        clear;
   logic [BYTE_COUNT_WIDTH:0]   byte_sum;
   logic [BYTE_COUNT_WIDTH-1:0] byte_sat;
   logic [RW-1:0]               rec_sat;
   logic [63:0]                 byte_wide;

   // limits
   always_ff @(posedge clock) begin
      if (reset) begin
         max_hdr_ff <= lprd_pkg::MAX_HEADER_RESET;
         max_raw_ff <= lprd_pkg::MAX_RAW_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lprd_pkg::CSR_MAX_HEADER_LENGTH: max_hdr_ff <= csr_wdata;
            lprd_pkg::CSR_MAX_RAW_LENGTH:    max_raw_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= lprd_pkg::PH_HLEN;
         idx_ff      <= '0;
         acc_ff      <= '0;
         rem_ff      <= '0;
         err_ff      <= lprd_pkg::ST_OK;
         rec_ff      <= '0;
         byte_cnt_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         idx_ff      <= idx_in;
         acc_ff      <= acc_in;
         rem_ff      <= rem_in;
         err_ff      <= err_in;
         rec_ff      <= rec_in;
         byte_cnt_ff <= byte_cnt_in;
      end
   end

   assign prefix_len  = {in_data_byte, acc_ff};
   assign prefix_done = (idx_ff == 2'd3);
   assign rem_last    = (rem_ff <= LW'(1));
   assign rec_sat     = (rec_ff == '1) ? rec_ff : rec_ff + RW'(1);
   assign byte_wide   = 64'(byte_cnt_ff);

   // carry out of the counter means the sum passed its range; it then saturates
   assign byte_sum = {1'b0, byte_cnt_ff} + (BYTE_COUNT_WIDTH + 1)'(add_amt);
   assign byte_sat = byte_sum[BYTE_COUNT_WIDTH] ? '1 : byte_sum[BYTE_COUNT_WIDTH-1:0];

   assign byte_cnt_in = clear ? '0 : byte_sat;

   always_comb begin
      acc_ins = acc_ff;
      unique case (idx_ff)
         2'd0:    acc_ins[7:0]   = in_data_byte;
         2'd1:    acc_ins[15:8]  = in_data_byte;
         2'd2:    acc_ins[23:16] = in_data_byte;
         default: acc_ins        = acc_ff;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      err_in    = err_ff;
      rec_in    = rec_ff;
      add_amt   = '0;
      clear     = 1'b0;
      out_valid = 1'b0;
      out_item  = '0;

      if (in_valid) begin
         if (in_op == lprd_pkg::OP_END) begin
            out_valid             = 1'b1;
            out_item.out_kind     = lprd_pkg::KIND_FINISH;
            out_item.record_total = rec_ff;
            out_item.byte_total   = byte_wide[lprd_pkg::BYTE_TOTAL_W-1:0];
            unique case (phase_ff)
               lprd_pkg::PH_HLEN: out_item.status = lprd_pkg::ST_OK;
               lprd_pkg::PH_HDR:  out_item.status = lprd_pkg::ST_SHORT_HEADER;
               lprd_pkg::PH_RLEN: out_item.status = lprd_pkg::ST_SHORT_RAW_LENGTH;
               lprd_pkg::PH_RAW:  out_item.status = lprd_pkg::ST_SHORT_RAW;
               lprd_pkg::PH_PAD:  out_item.status = lprd_pkg::ST_OK;
               default:           out_item.status = err_ff;
            endcase
            clear    = 1'b1;
            phase_in = lprd_pkg::PH_HLEN;
            idx_in   = '0;
            acc_in   = '0;
            rem_in   = '0;
            err_in   = lprd_pkg::ST_OK;
            rec_in   = '0;
         end else begin
            unique case (phase_ff)
               lprd_pkg::PH_HLEN: begin
                  if (prefix_done) begin
                     idx_in  = '0;
                     acc_in  = '0;
                     add_amt = 3'd4;
                     if (prefix_len > max_hdr_ff) begin
                        err_in   = lprd_pkg::ST_HEADER_TOO_LARGE;
                        phase_in = lprd_pkg::PH_ERR;
                     end else if (prefix_len == '0) begin
                        phase_in = lprd_pkg::PH_PAD;
                     end else begin
                        rem_in   = prefix_len;
                        phase_in = lprd_pkg::PH_HDR;
                     end
                  end else begin
                     acc_in = acc_ins;
                     idx_in = idx_ff + 2'd1;
                  end
               end
               lprd_pkg::PH_HDR: begin
                  add_amt              = 3'd1;
                  out_valid            = 1'b1;
                  out_item.out_kind    = lprd_pkg::KIND_HEADER;
                  out_item.header_byte = in_data_byte;
                  out_item.header_last = rem_last;
                  if (rem_last) begin
                     rem_in   = '0;
                     phase_in = lprd_pkg::PH_RLEN;
                     idx_in   = '0;
                     acc_in   = '0;
                  end else begin
                     rem_in = rem_ff - LW'(1);
                  end
               end
               lprd_pkg::PH_RLEN: begin
                  if (prefix_done) begin
                     idx_in  = '0;
                     acc_in  = '0;
                     add_amt = 3'd4;
                     if (prefix_len > max_raw_ff) begin
                        err_in   = lprd_pkg::ST_RAW_TOO_LARGE;
                        phase_in = lprd_pkg::PH_ERR;
                     end else begin
                        out_valid           = 1'b1;
                        out_item.out_kind   = lprd_pkg::KIND_RECORD;
                        out_item.raw_length = prefix_len;
                        if (prefix_len == '0) begin
                           rec_in   = rec_sat;
                           phase_in = lprd_pkg::PH_HLEN;
                        end else begin
                           rem_in   = prefix_len;
                           phase_in = lprd_pkg::PH_RAW;
                        end
                     end
                  end else begin
                     acc_in = acc_ins;
                     idx_in = idx_ff + 2'd1;
                  end
               end
               lprd_pkg::PH_RAW: begin
                  add_amt = 3'd1;
                  if (rem_last) begin
                     rem_in   = '0;
                     rec_in   = rec_sat;
                     phase_in = lprd_pkg::PH_HLEN;
                     idx_in   = '0;
                     acc_in   = '0;
                  end else begin
                     rem_in = rem_ff - LW'(1);
                  end
               end
               lprd_pkg::PH_PAD: begin
                  if (in_data_byte != 8'd0) begin
                     err_in   = lprd_pkg::ST_NONZERO_PADDING;
                     phase_in = lprd_pkg::PH_ERR;
                  end else begin
                     add_amt = 3'd1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // an error code is latched exactly while parked in the error phase
   a_err_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lprd_pkg::PH_ERR) == (err_ff != lprd_pkg::ST_OK))
      else $error("error code and error phase disagree");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_op == lprd_pkg::OP_END) |=>
         (phase_ff == lprd_pkg::PH_HLEN && rec_ff == '0 && byte_cnt_ff == '0))
      else $error("state not cleared after end of stream");

   a_err_frozen: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_op == lprd_pkg::OP_BYTE && phase_ff == lprd_pkg::PH_ERR) |=>
         ($stable(byte_cnt_ff) && $stable(rec_ff) && phase_ff == lprd_pkg::PH_ERR))
      else $error("bytes counted after an error");

   a_no_result_in_err: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_item.out_kind != lprd_pkg::KIND_FINISH) |->
         (phase_ff == lprd_pkg::PH_HDR || phase_ff == lprd_pkg::PH_RLEN))
      else $error("result item from a phase that gives none");

endmodule

>>> hw/rtl/lprd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_queue
// Back end: short result queue that holds finished items until the
// receiver pops them; the head item drives the result ports.
// ----------------------------------------------------------------------------
module lprd_queue #(
   parameter int DEPTH = lprd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lprd_pkg::rsp_item_type  push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    empty,
   output lprd_pkg::rsp_item_type  head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lprd_pkg::rsp_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign head_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("item pushed into a full queue");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not drain the queue");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule
